[design/cgpc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cgpc_pkg
// Shared constants and types for the cyclic generator polynomial check unit.
// ----------------------------------------------------------------------------
package cgpc_pkg;

    localparam int MAX_DEGREE  = 63;
    localparam int LENGTH_BITS = 16;

    localparam int POLY_BITS = MAX_DEGREE + 1;
    localparam int REM_BITS  = MAX_DEGREE;
    localparam int DEG_BITS  = (POLY_BITS > 1) ? $clog2(POLY_BITS) : 1;
    localparam int CMP_BITS  = (LENGTH_BITS > DEG_BITS) ? LENGTH_BITS : DEG_BITS;

    typedef enum logic [1:0] {
        ST_VALID    = 2'd0,
        ST_ZERO     = 2'd1,
        ST_MISMATCH = 2'd2,
        ST_REMAINS  = 2'd3
    } check_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_RUN,
        S_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic top;
    } cell_ctrl_t;

endpackage
`default_nettype wire

[design/cyclic_generator_poly_check_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cyclic_generator_poly_check_unit
// Checks whether a GF(2) polynomial generates the cyclic code C(l,k).
// ----------------------------------------------------------------------------
// A word whose remainder has to be computed goes from acceptance through a
// prep step that finds the degree and arms the division row, l shifts of the
// row of remainder cells, and a finish step that forms the result; when the
// zero, degree or trivial cases settle it, the shifts are skipped. The finish
// step waits while out_stall holds a result in the output register. One word
// is worked on at a time, and the next is taken once the result has moved to
// the output register.
module cyclic_generator_poly_check_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [15:0] code_length,
    input  wire logic [15:0] message_length,
    input  wire logic [63:0] generator_poly,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             is_generator,
    output logic [1:0]       status,
    output logic [5:0]       poly_degree
);
    import cgpc_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    logic [LENGTH_BITS-1:0] len_reg;
    logic [LENGTH_BITS-1:0] msg_reg;
    logic [POLY_BITS-1:0]   poly_reg;
    logic [DEG_BITS-1:0]    deg_reg;
    logic [LENGTH_BITS-1:0] cnt_reg;
    logic [LENGTH_BITS-1:0] cnt_next;
    logic [REM_BITS-1:0]    keep_reg;
    logic [REM_BITS-1:0]    taps_reg;
    logic [REM_BITS-1:0]    topsel_reg;
    check_status_t          early_reg;
    logic                   divide_reg;

    logic                   out_valid_reg;
    logic                   out_gen_reg;
    check_status_t          out_status_reg;
    logic [DEG_BITS-1:0]    out_deg_reg;

    logic [DEG_BITS-1:0]    deg_found;
    logic                   poly_zero;
    logic [REM_BITS-1:0]    rem;
    logic [REM_BITS-1:0]    keep_calc;
    logic [REM_BITS-1:0]    topsel_calc;
    logic [CMP_BITS-1:0]    diff;
    logic                   len_ok;
    check_status_t          early_calc;
    logic                   divide_calc;
    check_status_t          final_status;

    logic                   take_in;
    logic                   out_free;
    logic                   finish_load;
    logic                   run_last;
    cell_ctrl_t             cell_ctrl;

    cgpc_degree u_degree (
        .poly    (poly_reg),
        .degree  (deg_found),
        .is_zero (poly_zero)
    );

    always_comb
    begin
        for (int i = 0; i < REM_BITS; i++)
        begin
            keep_calc[i]   = (i < int'(deg_found));
            topsel_calc[i] = ((i + 1) == int'(deg_found));
        end
    end

    assign diff   = CMP_BITS'(len_reg) - CMP_BITS'(msg_reg);
    assign len_ok = (len_reg >= msg_reg) && (diff == CMP_BITS'(deg_found));

    always_comb
    begin
        early_calc  = ST_VALID;
        divide_calc = 1'b0;
        if (poly_zero)
        begin
            early_calc = ST_ZERO;
        end
        else if (!len_ok)
        begin
            early_calc = ST_MISMATCH;
        end
        else if ((deg_found != '0) && (len_reg != '0))
        begin
            divide_calc = 1'b1;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < REM_BITS; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_first
                cgpc_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .ctrl     (cell_ctrl),
                    .init_bit (1'b1),
                    .prev_bit (1'b0),
                    .keep     (keep_reg[gi]),
                    .tap      (taps_reg[gi]),
                    .rem_bit  (rem[gi])
                );
            end
            else
            begin : g_rest
                cgpc_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .ctrl     (cell_ctrl),
                    .init_bit (1'b0),
                    .prev_bit (rem[gi-1]),
                    .keep     (keep_reg[gi]),
                    .tap      (taps_reg[gi]),
                    .rem_bit  (rem[gi])
                );
            end
        end
    endgenerate

    assign cnt_next = cnt_reg + 1'b1;
    assign run_last = (cnt_next == len_reg);
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                state_next = divide_calc ? S_RUN : S_FINISH;
            end
            S_RUN:
            begin
                if (run_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall       = 1'b1;
        take_in        = 1'b0;
        finish_load    = 1'b0;
        cell_ctrl.load = 1'b0;
        cell_ctrl.step = 1'b0;
        cell_ctrl.top  = |(rem & topsel_reg);
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                take_in  = in_valid;
            end
            S_PREP:
            begin
                cell_ctrl.load = 1'b1;
            end
            S_RUN:
            begin
                cell_ctrl.step = 1'b1;
            end
            S_FINISH:
            begin
                finish_load = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    assign final_status = divide_reg ? ((rem == REM_BITS'(1)) ? ST_VALID : ST_REMAINS)
                                     : early_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (finish_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            len_reg  <= LENGTH_BITS'(code_length);
            msg_reg  <= LENGTH_BITS'(message_length);
            poly_reg <= POLY_BITS'(generator_poly);
        end
        if (state_reg == S_PREP)
        begin
            deg_reg    <= poly_zero ? '0 : deg_found;
            keep_reg   <= keep_calc;
            taps_reg   <= poly_reg[REM_BITS-1:0] & keep_calc;
            topsel_reg <= topsel_calc;
            early_reg  <= early_calc;
            divide_reg <= divide_calc;
            cnt_reg    <= '0;
        end
        else if (state_reg == S_RUN)
        begin
            cnt_reg <= cnt_next;
        end
        if (finish_load)
        begin
            out_gen_reg    <= (final_status == ST_VALID);
            out_status_reg <= final_status;
            out_deg_reg    <= deg_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign is_generator = out_gen_reg;
    assign status       = out_status_reg;
    assign poly_degree  = 6'(out_deg_reg);

endmodule
`default_nettype wire

[design/cgpc_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cgpc_cell
// One remainder bit of the division register, fed by its lower neighbor.
// ----------------------------------------------------------------------------
module cgpc_cell (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cgpc_pkg::cell_ctrl_t ctrl,
    input  wire logic                init_bit,
    input  wire logic                prev_bit,
    input  wire logic                keep,
    input  wire logic                tap,
    output logic                     rem_bit
);
    import cgpc_pkg::*;

    logic bit_reg;
    logic bit_next;

    always_comb
    begin
        bit_next = bit_reg;
        if (ctrl.load)
        begin
            bit_next = init_bit;
        end
        else if (ctrl.step)
        begin
            bit_next = (prev_bit & keep) ^ (ctrl.top & tap);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_reg <= 1'b0;
        end
        else
        begin
            bit_reg <= bit_next;
        end
    end

    assign rem_bit = bit_reg;

endmodule
`default_nettype wire

[design/cgpc_degree.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cgpc_degree
// Finds the index of the highest set bit of the polynomial.
// ----------------------------------------------------------------------------
module cgpc_degree (
    input  wire logic [cgpc_pkg::POLY_BITS-1:0] poly,
    output logic      [cgpc_pkg::DEG_BITS-1:0]  degree,
    output logic                                is_zero
);
    import cgpc_pkg::*;

    logic [POLY_BITS-1:0] highest;

    always_comb
    begin
        for (int i = 0; i < POLY_BITS; i++)
        begin
            highest[i] = poly[i] && ((poly >> (i + 1)) == '0);
        end
    end

    always_comb
    begin
        degree = '0;
        for (int i = 0; i < POLY_BITS; i++)
        begin
            degree = degree | (highest[i] ? DEG_BITS'(i) : '0);
        end
    end

    assign is_zero = (poly == '0);

endmodule
`default_nettype wire

[verif/cgpc_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgpc_result_checker
// Watches both channels of the cyclic generator polynomial check unit. For
// each accepted word it works out the verdict (status, generator flag and
// polynomial degree) with its own serial GF(2) division. It then compares
// every result word, field by field, with the oldest verdict still due.
// ----------------------------------------------------------------------------
module cgpc_result_checker
    import cgpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [15:0] code_length,
    input  logic [15:0] message_length,
    input  logic [63:0] generator_poly,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        is_generator,
    input  logic [1:0]  status,
    input  logic [5:0]  poly_degree,
    output int          mismatch_count,
    output int          words_pending,
    output int          results_checked,
    output int          generators_seen
);

    typedef struct packed {
        logic          is_gen;
        check_status_t code;
        logic [5:0]    degree;
    } verdict_t;

    verdict_t verdicts_due[$];
    int       mismatches = 0;
    int       pending    = 0;
    int       checked    = 0;
    int       valid_seen = 0;

    assign mismatch_count  = mismatches;
    assign words_pending   = pending;
    assign results_checked = checked;
    assign generators_seen = valid_seen;

    function automatic verdict_t gen_poly_verdict(input logic [15:0] l, input logic [15:0] k,
                                                  input logic [63:0] g);
        verdict_t    v;
        int unsigned d;
        int unsigned i;
        int unsigned n;
        logic [63:0] low_mask;
        logic [63:0] taps;
        logic [63:0] rem;
        logic        top_bit;
        d = 0;
        if (g == '0)
        begin
            v.code = ST_ZERO;
        end
        else
        begin
            for (i = 0; i < 64; i++)
            begin
                if (g[i])
                begin
                    d = i;
                end
            end
            if (l < k || (32'(l) - 32'(k)) != d)
            begin
                v.code = ST_MISMATCH;
            end
            else if (d == 0 || l == 0)
            begin
                v.code = ST_VALID;
            end
            else
            begin
                low_mask = (64'd1 << d) - 64'd1;
                taps     = g & low_mask;
                rem      = 64'd1;
                for (n = 0; n < l; n++)
                begin
                    top_bit = rem[d - 1];
                    rem     = (rem << 1) & low_mask;
                    if (top_bit)
                    begin
                        rem = rem ^ taps;
                    end
                end
                v.code = (rem == 64'd1) ? ST_VALID : ST_REMAINS;
            end
        end
        v.degree = d[5:0];
        v.is_gen = (v.code == ST_VALID);
        return v;
    endfunction

    always @(posedge clk)
    begin
        verdict_t due;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                verdicts_due.push_back(gen_poly_verdict(code_length, message_length,
                                                        generator_poly));
            end
            if (out_valid && !out_stall)
            begin
                checked++;
                if (verdicts_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("ERROR: result %0d arrived with no word outstanding", checked);
                    end
                end
                else
                begin
                    due = verdicts_due.pop_front();
                    if (due.is_gen)
                    begin
                        valid_seen++;
                    end
                    if (is_generator !== due.is_gen || status !== due.code ||
                        poly_degree !== due.degree)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("ERROR: result %0d: expected gen=%0b status=%0d deg=%0d, got gen=%0b status=%0d deg=%0d",
                                     checked, due.is_gen, due.code, due.degree,
                                     is_generator, status, poly_degree);
                        end
                    end
                end
            end
            pending = verdicts_due.size();
        end
    end

endmodule

[verif/tb_cyclic_generator_poly_check_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cyclic_generator_poly_check_unit
// Drives the cyclic generator polynomial check unit with directed corner
// words and then random ones, most of them built to match the degree so that
// the serial division runs. Both channels idle at random. A separate checker
// compares the results, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_cyclic_generator_poly_check_unit;

    import cgpc_pkg::*;

    localparam int HALF_PERIOD    = 6;
    localparam int WATCHDOG_LIMIT = 300000;
    localparam int RANDOM_WORDS   = 80;

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        in_valid       = 1'b0;
    logic        in_stall;
    logic [15:0] code_length    = '0;
    logic [15:0] message_length = '0;
    logic [63:0] generator_poly = '0;
    logic        out_valid;
    logic        out_stall      = 1'b0;
    logic        is_generator;
    logic [1:0]  status;
    logic [5:0]  poly_degree;

    logic        steady         = 1'b0;
    int          idle_cycles    = 0;
    int          words_sent     = 0;
    int          longest_length = 0;
    int          mismatch_count;
    int          words_pending;
    int          results_checked;
    int          generators_seen;

    cyclic_generator_poly_check_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .code_length    (code_length),
        .message_length (message_length),
        .generator_poly (generator_poly),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .is_generator   (is_generator),
        .status         (status),
        .poly_degree    (poly_degree)
    );

    cgpc_result_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .code_length     (code_length),
        .message_length  (message_length),
        .generator_poly  (generator_poly),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .is_generator    (is_generator),
        .status          (status),
        .poly_degree     (poly_degree),
        .mismatch_count  (mismatch_count),
        .words_pending   (words_pending),
        .results_checked (results_checked),
        .generators_seen (generators_seen)
    );

    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk)
    begin
        out_stall <= steady ? 1'b0 : ($urandom_range(99) < 34);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Timeout: no word moved for %0d cycles", idle_cycles);
                $display("Mismatches found");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic offer_word(input logic [15:0] l, input logic [15:0] k,
                              input logic [63:0] g);
        while (!steady && $urandom_range(99) < 34)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        code_length    <= l;
        message_length <= k;
        generator_poly <= g;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        words_sent++;
        if (int'(l) > longest_length)
        begin
            longest_length = l;
        end
    endtask

    initial
    begin
        int unsigned pick;
        int unsigned d;
        int unsigned m;
        int unsigned l;
        int unsigned k;
        logic [63:0] g;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer_word(16'd0, 16'd0, 64'd0);
        offer_word(16'hFFFF, 16'hFFFF, 64'd0);
        offer_word(16'd0, 16'd0, 64'd1);
        offer_word(16'hFFFF, 16'hFFFF, 64'd1);
        offer_word(16'd0, 16'd0, 64'd3);
        offer_word(16'd1, 16'd2, 64'd1);
        offer_word(16'd0, 16'hFFFF, 64'd1);
        offer_word(16'd7, 16'd4, 64'hB);
        offer_word(16'd7, 16'd4, 64'hD);
        offer_word(16'd7, 16'd4, 64'hF);
        offer_word(16'd1, 16'd0, 64'd3);
        offer_word(16'd2, 16'd0, 64'd5);
        offer_word(16'd5, 16'd3, 64'h7);
        offer_word(16'd100, 16'd99, 64'd2);
        offer_word(16'd64, 16'd1, '1);
        offer_word(16'd63, 16'd0, 64'h8000_0000_0000_0001);
        offer_word(16'd126, 16'd63, 64'h8000_0000_0000_0001);
        offer_word(16'hFFFF, 16'd0, 64'h8000_0000_0000_0000);
        offer_word(16'hFFFF, 16'hFFFE, 64'd3);
        offer_word(16'hFFFF, 16'hFFC0, '1);

        for (int w = 0; w < RANDOM_WORDS; w++)
        begin
            steady = (w >= 30 && w < 60);
            pick   = $urandom_range(99);
            g      = {$urandom, $urandom};
            if (pick < 30)
            begin
                d = $urandom_range(1, 63);
                m = $urandom_range(1, 8);
                l = d * m;
                k = l - d;
                g = (64'd1 << d) | 64'd1;
            end
            else if (pick < 45)
            begin
                d = $urandom_range(2, 64);
                m = $urandom_range(1, 4);
                l = d * m;
                k = l - d + 1;
                g = (d == 64) ? '1 : ((64'd1 << d) - 64'd1);
            end
            else if (pick < 55)
            begin
                l = $urandom_range(1, 300);
                k = l - 1;
                g = 64'd3;
            end
            else if (pick < 80)
            begin
                d = $urandom_range(1, 63);
                l = d + $urandom_range(0, 300);
                k = l - d;
                if (d < 63)
                begin
                    g = g & ((64'd1 << (d + 1)) - 64'd1);
                end
                g[d] = 1'b1;
            end
            else if (pick < 90)
            begin
                l = $urandom_range(0, 65535);
                k = $urandom_range(0, 65535);
                if (pick < 82)
                begin
                    g = '0;
                end
                else if (pick < 86)
                begin
                    g = g >> $urandom_range(63);
                end
            end
            else
            begin
                d = $urandom_range(1, 63);
                l = d * $urandom_range(1, 8);
                k = $urandom_range(1) ? (l - d + 1) : (l - d - 1);
                g = (64'd1 << d) | 64'd1;
            end
            offer_word(l[15:0], k[15:0], g);
        end
        steady = 1'b0;
        in_valid <= 1'b0;

        do
        begin
            @(posedge clk);
        end
        while (words_pending != 0);
        repeat (8) @(posedge clk);

        $display("Covered %0d words up to code length %0d:", words_sent, longest_length);
        $display("%0d results checked, %0d valid generators.",
                 results_checked, generators_seen);
        if (mismatch_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[filelist.f]
design/cgpc_pkg.sv
design/cgpc_cell.sv
design/cgpc_degree.sv
design/cyclic_generator_poly_check_unit.sv
verif/cgpc_result_checker.sv
verif/tb_cyclic_generator_poly_check_unit.sv
